// File: design/bsm_pkg.sv
`default_nettype none

package bsm_pkg;

    localparam int MAX_SIDE_DEF     = 1024;
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int SIDE_RESET       = 32;

    // A neighborhood holds at most nine pixels, so its pixel count fits in four bits.
    localparam int DIV_W   = 4;
    localparam int GROWTH_W = 4;

    // Which result row or column a result is for: the one before the pixel or the pixel's own.
    localparam logic SEL_PREV = 1'b0;
    localparam logic SEL_CUR  = 1'b1;

    typedef struct packed {
        logic load;
        logic fix;
    } bsm_div_ctl_t;

endpackage

`default_nettype wire

// File: design/bsm_mean_div.sv
`default_nettype none

module bsm_mean_div
    import bsm_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire bsm_div_ctl_t                  ctl,
    input  wire logic [CHANNEL_BITS+GROWTH_W-1:0] sum_in,
    input  wire logic [DIV_W-1:0]              div_in,
    output logic      [CHANNEL_BITS-1:0]       mean
);

    localparam int SUM_W = CHANNEL_BITS + GROWTH_W;
    localparam int RK = SUM_W;
    localparam int PROD_W = 2 * RK + 1;
    localparam longint unsigned ONE_SCALED = 64'd1 << RK;
    localparam logic [RK:0] RECIP_1 = (RK+1)'(ONE_SCALED);
    localparam logic [RK:0] RECIP_2 = (RK+1)'(ONE_SCALED / 2);
    localparam logic [RK:0] RECIP_3 = (RK+1)'(ONE_SCALED / 3);
    localparam logic [RK:0] RECIP_4 = (RK+1)'(ONE_SCALED / 4);
    localparam logic [RK:0] RECIP_6 = (RK+1)'(ONE_SCALED / 6);
    localparam logic [RK:0] RECIP_9 = (RK+1)'(ONE_SCALED / 9);

    logic [RK:0]           recip;
    logic [PROD_W-1:0]     prod_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [DIV_W-1:0]      div_reg;
    logic [RK-1:0]         q_est;
    logic [RK-1:0]         back;
    logic [RK-1:0]         rem;
    logic [RK-1:0]         q_fix;
    logic [CHANNEL_BITS-1:0] mean_reg;

    always_comb
    begin
        case (div_in)
            4'd2:    recip = RECIP_2;
            4'd3:    recip = RECIP_3;
            4'd4:    recip = RECIP_4;
            4'd6:    recip = RECIP_6;
            4'd9:    recip = RECIP_9;
            default: recip = RECIP_1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            prod_reg <= PROD_W'(sum_in) * PROD_W'(recip);
            sum_reg  <= sum_in;
            div_reg  <= div_in;
        end
    end

    // The reciprocal is rounded down, so the estimate is the quotient or one below it.
    always_comb
    begin
        q_est = prod_reg[2*RK-1:RK];
        back  = q_est * {{(RK-DIV_W){1'b0}}, div_reg};
        rem   = sum_reg - back;
        q_fix = (rem >= {{(RK-DIV_W){1'b0}}, div_reg}) ? q_est + {{(RK-1){1'b0}}, 1'b1}
                                                       : q_est;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fix)
        begin
            mean_reg <= q_fix[CHANNEL_BITS-1:0];
        end
    end

    assign mean = mean_reg;

endmodule

`default_nettype wire

// File: design/box_smooth_3x3_rgb.sv
`default_nettype none

// 3x3 box smoothing of a square RGB image streamed in raster order. The block counts row and
// column itself; cfg_data sets the side (0 acts as 1, values above MAX_SIDE act as MAX_SIDE)
// and every write restarts the frame at row 0, column 0. Write it only while the block is idle.
// Each result is the truncated per-channel mean of the pixel's 3x3 neighborhood clipped to the
// image, tagged with its row and column. A result leaves as soon as its neighborhood is
// complete: pixels of row 0 and of column 0 give none, the last pixel of a row gives two, each
// pixel of the last row gives two, the last pixel of the image gives four, and at side 1 the
// one pixel gives one. tlast marks the last result caused by an input beat, tuser marks the
// result for the bottom-right pixel. One pixel is taken per clock while m_axis is not stalled;
// a pixel with several results holds the result sequencer until its last result leaves, which
// slows the input at row ends and on the last row. The two previous rows live in one line memory
// of MAX_SIDE words with a registered read; there is no clearing pass, and entries never written
// only feed window positions that the clipping excludes.
module box_smooth_3x3_rgb
    import bsm_pkg::*;
#(
    parameter int MAX_SIDE     = MAX_SIDE_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    localparam int POS_W      = $clog2(MAX_SIDE),
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1),
    localparam int PIX_W      = 3 * CHANNEL_BITS,
    localparam int IN_DATA_W  = ((PIX_W + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((PIX_W + 2 * POS_W + 7) / 8) * 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [SIDE_W-1:0]     cfg_data,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0 up: in_red, in_green, in_blue.
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Fields from bit 0 up: out_red, out_green, out_blue, out_row, out_col, zero fill.
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,
    // Fields from bit 0 up: frame_end.
    output logic                       m_axis_tuser
);

    localparam int CB     = CHANNEL_BITS;
    localparam int SUM_W  = CB + GROWTH_W;
    localparam int LINE_W = 2 * PIX_W;
    localparam int SIDE_RST_CLAMP = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
    localparam logic [POS_W-1:0] SIDE_LAST_RST = POS_W'(SIDE_RST_CLAMP - 1);
    localparam logic [POS_W-1:0] SIDE_LAST_MAX = POS_W'(MAX_SIDE - 1);
    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);
    localparam logic [SIDE_W-1:0] SIDE_ONE = SIDE_W'(1);
    localparam logic [POS_W-1:0] ONE_POS = POS_W'(1);

    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic r_last;
        logic c_ge1;
        logic c_ge2;
        logic c_last;
    } pos_flags_t;

    // Configuration and position counters.
    logic [POS_W-1:0]  side_last_reg;
    logic [POS_W-1:0]  side_last_next;
    logic [SIDE_W-1:0] side_minus;
    logic [POS_W-1:0]  row_reg;
    logic [POS_W-1:0]  col_reg;
    pos_flags_t        in_flags;

    // Pipeline control.
    logic in_fire;
    logic s1_rdy;
    logic s1_fire;
    logic s2_rdy;
    logic s2_done;
    logic s3_rdy;
    logic s4_rdy;
    logic s5_rdy;
    logic emit;
    logic s1_vld_reg;
    logic s2_vld_reg;
    logic s3_vld_reg;
    logic s4_vld_reg;
    logic s5_vld_reg;

    // Line memory: prior row in the upper half, older row in the lower half.
    logic [LINE_W-1:0] line_mem [MAX_SIDE];
    logic [LINE_W-1:0] line_rd_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic              fwd_reg;
    logic [LINE_W-1:0] s1_line;
    logic [PIX_W-1:0]  s1_older;
    logic [PIX_W-1:0]  s1_prior;

    // Stage 1.
    logic [PIX_W-1:0]  s1_px_reg;
    logic [POS_W-1:0]  s1_row_reg;
    logic [POS_W-1:0]  s1_col_reg;
    pos_flags_t        s1_flg_reg;

    // Stage 2: window and result sequencer.
    logic [PIX_W-1:0]  win_reg [3][3];
    logic [POS_W-1:0]  s2_row_reg;
    logic [POS_W-1:0]  s2_col_reg;
    pos_flags_t        s2_flg_reg;
    logic              rs_reg;
    logic              cs_reg;
    logic              has_res;
    logic              last_rs;
    logic              last_cs;
    logic              res_last;
    logic              col_first;
    logic [2:0]        rinc;
    logic [2:0]        cinc;
    logic [1:0]        nrow;
    logic [1:0]        ncol;
    logic [DIV_W-1:0]  s2_div;
    logic [SUM_W-1:0]  s2_sum [3];
    logic [POS_W-1:0]  s2_out_row;
    logic [POS_W-1:0]  s2_out_col;

    // Stage 3 to 5.
    logic [SUM_W-1:0]  s3_sum_reg [3];
    logic [DIV_W-1:0]  s3_div_reg;
    logic [POS_W-1:0]  s3_row_reg;
    logic [POS_W-1:0]  s3_col_reg;
    logic              s3_last_reg;
    logic              s3_fend_reg;
    logic [POS_W-1:0]  s4_row_reg;
    logic [POS_W-1:0]  s4_col_reg;
    logic              s4_last_reg;
    logic              s4_fend_reg;
    logic [POS_W-1:0]  s5_row_reg;
    logic [POS_W-1:0]  s5_col_reg;
    logic              s5_last_reg;
    logic              s5_fend_reg;
    logic [CB-1:0]     s5_mean [3];
    bsm_div_ctl_t      div_ctl;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        side_minus = cfg_data - SIDE_ONE;
        if (cfg_data == '0)
        begin
            side_last_next = '0;
        end
        else if (cfg_data > SIDE_MAX)
        begin
            side_last_next = SIDE_LAST_MAX;
        end
        else
        begin
            side_last_next = side_minus[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_last_reg <= SIDE_LAST_RST;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            side_last_reg <= side_last_next;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else if (in_fire)
        begin
            if (col_reg == side_last_reg)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == side_last_reg) ? '0 : row_reg + ONE_POS;
            end
            else
            begin
                col_reg <= col_reg + ONE_POS;
            end
        end
    end

    always_comb
    begin
        in_flags.r_ge1  = (row_reg != '0);
        in_flags.r_ge2  = (row_reg > ONE_POS);
        in_flags.r_last = (row_reg == side_last_reg);
        in_flags.c_ge1  = (col_reg != '0);
        in_flags.c_ge2  = (col_reg > ONE_POS);
        in_flags.c_last = (col_reg == side_last_reg);
    end

    // Handshake chain; stage 2 moves once its pixel is done, others when the next has room.
    assign s5_rdy  = !s5_vld_reg || m_axis_tready;
    assign s4_rdy  = !s4_vld_reg || s5_rdy;
    assign s3_rdy  = !s3_vld_reg || s4_rdy;
    assign emit    = s2_vld_reg && has_res && s3_rdy;
    assign s2_done = s2_vld_reg && (!has_res || (s3_rdy && res_last));
    assign s2_rdy  = !s2_vld_reg || s2_done;
    assign s1_rdy  = !s1_vld_reg || s2_rdy;
    assign s1_fire = s1_vld_reg && s2_rdy;
    assign in_fire = s_axis_tvalid && s1_rdy;
    assign s_axis_tready = s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_vld_reg <= in_fire;
            end
            if (s2_rdy)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (s3_rdy)
            begin
                s3_vld_reg <= emit;
            end
            if (s4_rdy)
            begin
                s4_vld_reg <= s3_vld_reg;
            end
            if (s5_rdy)
            begin
                s5_vld_reg <= s4_vld_reg;
            end
        end
    end

    // Read at the beat, write back one stage later: the prior row moves down, the pixel goes in.
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            line_mem[s1_col_reg] <= {s1_px_reg, s1_prior};
        end
        if (in_fire)
        begin
            line_rd_reg  <= line_mem[col_reg];
            fwd_data_reg <= {s1_px_reg, s1_prior};
        end
    end

    // A write-back to the column being read in the same cycle bypasses the memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            fwd_reg <= s1_fire && (s1_col_reg == col_reg);
        end
    end

    assign s1_line  = fwd_reg ? fwd_data_reg : line_rd_reg;
    assign s1_older = s1_line[PIX_W-1:0];
    assign s1_prior = s1_line[LINE_W-1:PIX_W];

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg  <= s_axis_tdata[PIX_W-1:0];
            s1_row_reg <= row_reg;
            s1_col_reg <= col_reg;
            s1_flg_reg <= in_flags;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            for (int a = 0; a < 3; a++)
            begin
                win_reg[a][0] <= win_reg[a][1];
                win_reg[a][1] <= win_reg[a][2];
            end
            win_reg[0][2] <= s1_older;
            win_reg[1][2] <= s1_prior;
            win_reg[2][2] <= s1_px_reg;
            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_reg;
            s2_flg_reg    <= s1_flg_reg;
        end
    end

    always_comb
    begin
        has_res   = (s2_flg_reg.r_ge1 || s2_flg_reg.r_last) &&
                    (s2_flg_reg.c_ge1 || s2_flg_reg.c_last);
        last_rs   = (rs_reg == SEL_CUR) || !s2_flg_reg.r_last;
        last_cs   = (cs_reg == SEL_CUR) || !s2_flg_reg.c_last;
        res_last  = last_rs && last_cs;
        col_first = s2_flg_reg.c_ge1 ? SEL_PREV : SEL_CUR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg <= SEL_PREV;
            cs_reg <= SEL_PREV;
        end
        else if (s1_fire)
        begin
            rs_reg <= s1_flg_reg.r_ge1 ? SEL_PREV : SEL_CUR;
            cs_reg <= s1_flg_reg.c_ge1 ? SEL_PREV : SEL_CUR;
        end
        else if (emit && !res_last)
        begin
            if (last_cs)
            begin
                rs_reg <= SEL_CUR;
                cs_reg <= col_first;
            end
            else
            begin
                cs_reg <= SEL_CUR;
            end
        end
    end

    always_comb
    begin
        rinc[2] = 1'b1;
        rinc[1] = (rs_reg == SEL_PREV) || s2_flg_reg.r_ge1;
        rinc[0] = (rs_reg == SEL_PREV) && s2_flg_reg.r_ge2;
        cinc[2] = 1'b1;
        cinc[1] = (cs_reg == SEL_PREV) || s2_flg_reg.c_ge1;
        cinc[0] = (cs_reg == SEL_PREV) && s2_flg_reg.c_ge2;
        nrow    = 2'd1 + {1'b0, rinc[1]} + {1'b0, rinc[0]};
        ncol    = 2'd1 + {1'b0, cinc[1]} + {1'b0, cinc[0]};
        s2_div  = {2'b00, nrow} * {2'b00, ncol};
        s2_out_row = (rs_reg == SEL_PREV) ? s2_row_reg - ONE_POS : s2_row_reg;
        s2_out_col = (cs_reg == SEL_PREV) ? s2_col_reg - ONE_POS : s2_col_reg;
        for (int ch = 0; ch < 3; ch++)
        begin
            s2_sum[ch] = '0;
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    if (rinc[a] && cinc[b])
                    begin
                        s2_sum[ch] = s2_sum[ch] + SUM_W'(win_reg[a][b][ch*CB +: CB]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                s3_sum_reg[ch] <= s2_sum[ch];
            end
            s3_div_reg  <= s2_div;
            s3_row_reg  <= s2_out_row;
            s3_col_reg  <= s2_out_col;
            s3_last_reg <= res_last;
            s3_fend_reg <= (rs_reg == SEL_CUR) && (cs_reg == SEL_CUR);
        end
        if (s4_rdy)
        begin
            s4_row_reg  <= s3_row_reg;
            s4_col_reg  <= s3_col_reg;
            s4_last_reg <= s3_last_reg;
            s4_fend_reg <= s3_fend_reg;
        end
        if (s5_rdy)
        begin
            s5_row_reg  <= s4_row_reg;
            s5_col_reg  <= s4_col_reg;
            s5_last_reg <= s4_last_reg;
            s5_fend_reg <= s4_fend_reg;
        end
    end

    assign div_ctl.load = s4_rdy;
    assign div_ctl.fix  = s5_rdy;

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        bsm_mean_div #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_div (
            .clk    (clk),
            .ctl    (div_ctl),
            .sum_in (s3_sum_reg[g]),
            .div_in (s3_div_reg),
            .mean   (s5_mean[g])
        );
    end

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[CB-1:0]              = s5_mean[0];
        m_axis_tdata[2*CB-1:CB]           = s5_mean[1];
        m_axis_tdata[PIX_W-1:2*CB]        = s5_mean[2];
        m_axis_tdata[PIX_W+POS_W-1:PIX_W] = s5_row_reg;
        m_axis_tdata[PIX_W+2*POS_W-1:PIX_W+POS_W] = s5_col_reg;
    end

    assign m_axis_tvalid = s5_vld_reg;
    assign m_axis_tlast  = s5_last_reg;
    assign m_axis_tuser  = s5_fend_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end result is not the last of its pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        emit && !res_last |=> s2_vld_reg)
        else $error("pixel left the sequencer before its last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s3_vld_reg) |-> $past(emit))
        else $error("result stage filled without a sequencer result");

    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (s2_div == 4'd1 || s2_div == 4'd2 || s2_div == 4'd3 ||
                  s2_div == 4'd4 || s2_div == 4'd6 || s2_div == 4'd9))
        else $error("neighborhood pixel count out of range");

endmodule

`default_nettype wire

// File: test/box_smooth_3x3_rgb_tb.sv
`timescale 1ns / 100ps

module box_smooth_3x3_rgb_tb;
    import bsm_pkg::*;

    localparam int SIDE_W       = $clog2(MAX_SIDE_DEF + 1);
    localparam int POS_W        = $clog2(MAX_SIDE_DEF);
    localparam int PIX_W        = 3 * CHANNEL_BITS_DEF;
    localparam int IN_DATA_W    = ((PIX_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((PIX_W + 2 * POS_W + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_ITEMS = 250;

    typedef bit [PIX_W-1:0] pixel_t;

    typedef struct {
        bit [CHANNEL_BITS_DEF-1:0] red;
        bit [CHANNEL_BITS_DEF-1:0] green;
        bit [CHANNEL_BITS_DEF-1:0] blue;
        bit [POS_W-1:0]            row;
        bit [POS_W-1:0]            col;
        bit                        last;
        bit                        fend;
    } smooth_result_t;

    class smooth_scoreboard;
        bit [SIDE_W-1:0] side;
        int              row_pos;
        int              col_pos;
        pixel_t          older_row[MAX_SIDE_DEF];
        pixel_t          prior_row[MAX_SIDE_DEF];
        pixel_t          win[9];
        smooth_result_t  expected_q[$];
        int              errors;
        int              checked;

        function new();
            side    = SIDE_W'(SIDE_RESET);
            row_pos = 0;
            col_pos = 0;
            errors  = 0;
            checked = 0;
        endfunction

        function int active_side();
            if (side < 1)
                return 1;
            if (side > MAX_SIDE_DEF)
                return MAX_SIDE_DEF;
            return int'(side);
        endfunction

        function void set_side(bit [SIDE_W-1:0] value);
            side    = value;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Shifts the pixel into the line stores and the window and queues every
        // neighborhood that this pixel completes, in raster order.
        function void note_pixel(pixel_t px);
            int n, r, c, nr, nc, k, x, y, i, j, a, b, ch, cnt;
            int lo_r, hi_r, lo_c, hi_c;
            int rows[2];
            int cols[2];
            bit [31:0] sum[3];
            smooth_result_t found[4];
            n = active_side();
            r = row_pos;
            c = col_pos;
            if (r >= n)
                r = 0;
            if (c >= n)
                c = 0;
            for (a = 0; a < 3; a++)
            begin
                win[a * 3]     = win[a * 3 + 1];
                win[a * 3 + 1] = win[a * 3 + 2];
            end
            win[2] = older_row[c];
            win[5] = prior_row[c];
            win[8] = px;
            older_row[c] = prior_row[c];
            prior_row[c] = px;
            nr = 0;
            nc = 0;
            if (r >= 1)
            begin
                rows[nr] = r - 1;
                nr++;
            end
            if (r == n - 1)
            begin
                rows[nr] = r;
                nr++;
            end
            if (c >= 1)
            begin
                cols[nc] = c - 1;
                nc++;
            end
            if (c == n - 1)
            begin
                cols[nc] = c;
                nc++;
            end
            k = 0;
            for (x = 0; x < nr; x++)
            begin
                for (y = 0; y < nc; y++)
                begin
                    i = rows[x];
                    j = cols[y];
                    lo_r = ((i - 1 < 0) ? 0 : i - 1) + 2 - r;
                    hi_r = ((i + 1 > n - 1) ? n - 1 : i + 1) + 2 - r;
                    lo_c = ((j - 1 < 0) ? 0 : j - 1) + 2 - c;
                    hi_c = ((j + 1 > n - 1) ? n - 1 : j + 1) + 2 - c;
                    sum = '{0, 0, 0};
                    cnt = 0;
                    for (a = lo_r; a <= hi_r; a++)
                    begin
                        for (b = lo_c; b <= hi_c; b++)
                        begin
                            if (a >= 0 && a <= 2 && b >= 0 && b <= 2)
                            begin
                                for (ch = 0; ch < 3; ch++)
                                    sum[ch] += win[a * 3 + b][CHANNEL_BITS_DEF * ch
                                                              +: CHANNEL_BITS_DEF];
                                cnt++;
                            end
                        end
                    end
                    if (cnt == 0)
                        cnt = 1;
                    found[k].red   = CHANNEL_BITS_DEF'(sum[0] / cnt);
                    found[k].green = CHANNEL_BITS_DEF'(sum[1] / cnt);
                    found[k].blue  = CHANNEL_BITS_DEF'(sum[2] / cnt);
                    found[k].row   = POS_W'(i);
                    found[k].col   = POS_W'(j);
                    found[k].last  = 1'b0;
                    found[k].fend  = (i == n - 1) && (j == n - 1);
                    k++;
                end
            end
            if (k > 0)
                found[k - 1].last = 1'b1;
            for (x = 0; x < k; x++)
                expected_q.push_back(found[x]);
            c++;
            if (c >= n)
            begin
                c = 0;
                r++;
                if (r >= n)
                    r = 0;
            end
            row_pos = r;
            col_pos = c;
        endfunction

        function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (act_val !== exp_val)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                         act_val);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last, logic fend);
            smooth_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual data %0h", $time,
                         data);
                return;
            end
            e = expected_q.pop_front();
            compare_field("out_red", 32'(e.red), 32'(data[15:0]));
            compare_field("out_green", 32'(e.green), 32'(data[31:16]));
            compare_field("out_blue", 32'(e.blue), 32'(data[47:32]));
            compare_field("out_row", 32'(e.row), 32'(data[57:48]));
            compare_field("out_col", 32'(e.col), 32'(data[67:58]));
            compare_field("run_last", 32'(e.last), 32'(last));
            compare_field("frame_end", 32'(e.fend), 32'(fend));
            checked++;
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [SIDE_W-1:0]     cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    smooth_scoreboard sb;
    bit               calm;
    int               cycle_count = 0;
    int               pixels_sent;
    int               side_writes;

    box_smooth_3x3_rgb u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                     sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (calm)
            return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 11) : 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic pixel_t rand_pixel();
        int     mode;
        pixel_t px;
        int     ch;
        mode = $urandom_range(0, 9);
        px   = PIX_W'({$urandom, $urandom});
        if (mode == 0)
            px = '0;
        else if (mode == 1)
            px = '1;
        else if (mode == 2)
        begin
            for (ch = 0; ch < 3; ch++)
                px[CHANNEL_BITS_DEF * ch +: CHANNEL_BITS_DEF] =
                    {CHANNEL_BITS_DEF{$urandom_range(0, 1) == 1}};
        end
        return px;
    endfunction

    task automatic send_pixel(pixel_t px);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    task automatic stop_input();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_results();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic end_phase();
        stop_input();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_side(bit [SIDE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_side(value);
        side_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random pixels; once per run the sender holds off until the output has drained.
    task automatic run_pixels(int count);
        int idx;
        int pause_at;
        pause_at = $urandom_range(0, count - 1);
        for (idx = 0; idx < count; idx++)
        begin
            if (idx == pause_at)
            begin
                stop_input();
                wait_results();
            end
            send_pixel(rand_pixel());
        end
    endtask

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    initial
    begin
        int          random_items;
        int          sel;
        int          shape;
        int          side;
        int          n;
        int          count;
        int          k;
        sb            = new();
        calm          = 1'b0;
        pixels_sent   = 0;
        side_writes   = 0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // The side after reset, checked through the first neighborhoods that row 1 completes.
        run_pixels(36);
        end_phase();

        write_side(SIDE_W'(1));
        send_pixel('0);
        send_pixel('1);
        send_pixel({16'hFFFF, 16'h0000, 16'h8001});
        end_phase();

        write_side(SIDE_W'(0));
        send_pixel({16'h0001, 16'h8000, 16'h7FFF});
        send_pixel(rand_pixel());
        end_phase();

        write_side(SIDE_W'(2));
        repeat (4) send_pixel('1);
        end_phase();

        write_side(SIDE_W'(3));
        for (k = 0; k < 9; k++)
            send_pixel((k % 2 == 1) ? {16'h0000, 16'hFFFF, 16'h0000}
                                    : {16'hFFFF, 16'h0000, 16'hFFFF});
        end_phase();

        write_side(SIDE_W'(2047));
        repeat (3) send_pixel(rand_pixel());
        end_phase();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            sel  = $urandom_range(0, 19);
            side = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            n    = (side < 1) ? 1 : side;
            shape = $urandom_range(0, 5);
            if (sel == 1)
                count = $urandom_range(2 * n, 4 * n);
            else if (shape == 0)
                count = $urandom_range(1, n * n);
            else if (shape == 1)
                count = 2 * n * n;
            else
                count = n * n;
            calm = ($urandom_range(0, 3) == 0);
            write_side(SIDE_W'(side));
            run_pixels(count);
            end_phase();
            random_items += count;
        end

        // The largest side for a few beats of row 0, which complete no neighborhood.
        calm = 1'b1;
        write_side(SIDE_W'(MAX_SIDE_DEF));
        run_pixels(8);
        end_phase();

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d pixels over %0d side settings (0, 1, small frames, 1024, 2047).",
                 pixels_sent, side_writes);
        $display("Checked %0d smoothed results, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
design/bsm_pkg.sv
design/bsm_mean_div.sv
design/box_smooth_3x3_rgb.sv
test/box_smooth_3x3_rgb_tb.sv
